/* rtl/rcats_pkg.sv */
`default_nettype none
package rcats_pkg;

	localparam int TEXT_DEPTH    = 4096;
	localparam int PATTERN_DEPTH = 256;
	localparam int ALPHABET      = 256;
	localparam int MAX_EMIT      = 63;

	localparam int TAW = $clog2(TEXT_DEPTH);
	localparam int TLW = TAW + 1;
	localparam int PAW = $clog2(PATTERN_DEPTH);
	localparam int PLW = PAW + 1;
	localparam int AAW = $clog2(ALPHABET);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_TEXT  = 2'd1,
		STAT_PAT_LONG = 2'd2
	} status_t;

	typedef struct packed {
		logic [TAW-1:0] pos;
		logic           valid;
		logic [TLW-1:0] count;
		logic           ovf;
		status_t        status;
		logic           fin;
	} result_t;

endpackage
`default_nettype wire

/* rtl/rare_char_anchored_text_search.sv */
`default_nettype none
// Substring search over a loaded text, anchored on the rarest pattern byte.
// Input channel (in_valid / in_stall): one word per byte. req_type 0 loads a
// text byte, 1 a pattern byte; end_of_string marks the last byte. A text byte
// arriving after an index is built starts a new text. Text bytes past 4096
// drop. Non-final bytes of either kind are stored while the block stays idle.
// The last text byte builds the index on single-port RAMs: it clears the
// counts, counts every text byte, forms the prefix sums and buckets the
// positions. The last pattern byte runs a search: it reads the count of each
// pattern byte to find the rarest, then compares the pattern at each anchor.
// Output channel (out_valid / out_stall): up to 63 match words in ascending
// start order, then one final word with the exact count, the overflow flag
// and the status. The output register holds while out_stall is high; the
// search sequencer waits for it and in_stall stays high until done.
// Reset clears control state; the index is invalid until a text ends.
module rare_char_anchored_text_search (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      req_type,
	input  wire logic [7:0]                data_byte,
	input  wire logic                      end_of_string,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [rcats_pkg::TAW-1:0]      match_position,
	output logic                           match_valid,
	output logic [rcats_pkg::TLW-1:0]      match_count,
	output logic                           count_overflow,
	output logic [1:0]                     status,
	output logic                           final_result
);
	import rcats_pkg::*;

	logic    busy, res_ready, res_push;
	result_t res, res_q;
	logic    out_valid_q;

	// accept a new word only while the sequencer sits idle
	assign in_stall  = busy;
	// the output register is free when empty or being drained
	assign res_ready = !out_valid_q || !out_stall;

	rcats_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_valid && !busy),
		.req_type(req_type),
		.data_byte(data_byte),
		.end_of_string(end_of_string),
		.busy(busy),
		.res_ready(res_ready),
		.res_push(res_push),
		.res(res)
	);

	// hold a stalled word, advance on push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_push) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign match_position = res_q.pos;
	assign match_valid    = res_q.valid;
	assign match_count    = res_q.count;
	assign count_overflow = res_q.ovf;
	assign status         = res_q.status;
	assign final_result   = res_q.fin;

endmodule
`default_nettype wire

/* rtl/rcats_ram.sv */
`default_nettype none
module rcats_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

/* rtl/rcats_seq.sv */
`default_nettype none
module rcats_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_fire,
	input  wire logic                req_type,
	input  wire logic [7:0]          data_byte,
	input  wire logic                end_of_string,
	output logic                     busy,
	input  wire logic                res_ready,
	output logic                     res_push,
	output rcats_pkg::result_t       res
);
	import rcats_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE     = 22'h000001,
		S_DECIDE   = 22'h000002,
		S_CLR      = 22'h000004,
		S_CNT_RD   = 22'h000008,
		S_CNT_INC  = 22'h000010,
		S_CNT_WR   = 22'h000020,
		S_SUM_RD   = 22'h000040,
		S_SUM_WR   = 22'h000080,
		S_FIL_RD   = 22'h000100,
		S_FIL_SLOT = 22'h000200,
		S_FIL_WR   = 22'h000400,
		S_MIN_RD   = 22'h000800,
		S_MIN_CNT  = 22'h001000,
		S_MIN_CMP  = 22'h002000,
		S_OFS_RD   = 22'h004000,
		S_OFS_SUB  = 22'h008000,
		S_POS_RD   = 22'h010000,
		S_POS_CHK  = 22'h020000,
		S_CMP_RD   = 22'h040000,
		S_CMP_CHK  = 22'h080000,
		S_EMIT     = 22'h100000,
		S_FINAL    = 22'h200000
	} state_t;

	state_t         state_q;
	logic [TLW-1:0] tlen_q, i_q, run_q, minc_q, k_q, end_q, total_q;
	logic [PLW-1:0] plen_q, j_q;
	logic           ready_q, pover_q;
	logic [7:0]     byte_q, best_q;
	logic [PAW-1:0] anchor_q;
	logic [TAW-1:0] start_q;
	status_t        fstat_q;

	logic           txt_we, cnt_we, fil_we, pos_we, pat_we;
	logic [TAW-1:0] txt_addr, pos_addr, pos_wdata, pos_rd;
	logic [AAW-1:0] cnt_addr, fil_addr;
	logic [PAW-1:0] pat_addr;
	logic [7:0]     txt_wdata, txt_rd, pat_rd;
	logic [TLW-1:0] cnt_wdata, cnt_rd, fil_wdata, fil_rd;

	logic [TLW-1:0] eff_len;
	logic [TAW-1:0] st;

	assign eff_len = ready_q ? '0 : tlen_q;
	assign st      = pos_rd - TAW'(anchor_q);
	assign busy    = (state_q != S_IDLE);

	rcats_ram #(.DEPTH(TEXT_DEPTH), .WIDTH(8)) u_text (
		.clk(clk), .we(txt_we), .addr(txt_addr), .wdata(txt_wdata), .rdata(txt_rd));
	rcats_ram #(.DEPTH(TEXT_DEPTH), .WIDTH(TAW)) u_pos (
		.clk(clk), .we(pos_we), .addr(pos_addr), .wdata(pos_wdata), .rdata(pos_rd));
	rcats_ram #(.DEPTH(ALPHABET), .WIDTH(TLW)) u_cnt (
		.clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rd));
	rcats_ram #(.DEPTH(ALPHABET), .WIDTH(TLW)) u_fill (
		.clk(clk), .we(fil_we), .addr(fil_addr), .wdata(fil_wdata), .rdata(fil_rd));
	rcats_ram #(.DEPTH(PATTERN_DEPTH), .WIDTH(8)) u_pat (
		.clk(clk), .we(pat_we), .addr(pat_addr), .wdata(data_byte), .rdata(pat_rd));

	// memory port steering
	always_comb begin
		txt_we    = 1'b0;
		txt_addr  = i_q[TAW-1:0];
		txt_wdata = data_byte;
		pos_we    = 1'b0;
		pos_addr  = k_q[TAW-1:0];
		pos_wdata = i_q[TAW-1:0];
		cnt_we    = 1'b0;
		cnt_addr  = i_q[AAW-1:0];
		cnt_wdata = '0;
		fil_we    = 1'b0;
		fil_addr  = i_q[AAW-1:0];
		fil_wdata = run_q;
		pat_we    = 1'b0;
		pat_addr  = j_q[PAW-1:0];
		case (state_q)
			S_IDLE: begin
				txt_addr = eff_len[TAW-1:0];
				txt_we   = in_fire && !req_type && (eff_len < TLW'(TEXT_DEPTH));
				pat_addr = plen_q[PAW-1:0];
				pat_we   = in_fire && req_type && (plen_q < PLW'(PATTERN_DEPTH));
			end
			S_CLR:      cnt_we = 1'b1;
			S_CNT_INC:  cnt_addr = txt_rd;
			S_CNT_WR: begin
				cnt_addr  = byte_q;
				cnt_we    = 1'b1;
				cnt_wdata = cnt_rd + 1'b1;
			end
			S_SUM_WR:   fil_we = 1'b1;
			S_FIL_SLOT: fil_addr = txt_rd;
			S_FIL_WR: begin
				pos_addr  = fil_rd[TAW-1:0];
				pos_we    = 1'b1;
				fil_addr  = byte_q;
				fil_we    = 1'b1;
				fil_wdata = fil_rd + 1'b1;
			end
			S_MIN_CNT:  cnt_addr = pat_rd;
			S_OFS_RD:   fil_addr = best_q;
			S_CMP_RD:   txt_addr = start_q + TAW'(j_q);
			default: ;
		endcase
	end

	always_comb begin
		res_push = 1'b0;
		res      = '0;
		if (state_q == S_EMIT) begin
			res_push  = res_ready;
			res.pos   = start_q;
			res.valid = 1'b1;
		end else if (state_q == S_FINAL) begin
			res_push   = res_ready;
			res.count  = total_q;
			res.ovf    = total_q > TLW'(MAX_EMIT);
			res.status = fstat_q;
			res.fin    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			tlen_q   <= '0;
			plen_q   <= '0;
			ready_q  <= 1'b0;
			pover_q  <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			total_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire && !req_type) begin
						ready_q <= 1'b0;
						tlen_q  <= (eff_len < TLW'(TEXT_DEPTH)) ? eff_len + 1'b1 : eff_len;
						if (end_of_string) begin
							i_q     <= '0;
							state_q <= S_CLR;
						end
					end else if (in_fire) begin
						if (plen_q < PLW'(PATTERN_DEPTH)) begin
							plen_q <= plen_q + 1'b1;
						end else begin
							pover_q <= 1'b1;
						end
						if (end_of_string) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					total_q <= '0;
					fstat_q <= STAT_OK;
					minc_q  <= '1;
					j_q     <= '0;
					if (pover_q) begin
						fstat_q <= STAT_PAT_LONG;
						state_q <= S_FINAL;
					end else if (!ready_q) begin
						fstat_q <= STAT_NO_TEXT;
						state_q <= S_FINAL;
					end else if (plen_q == '0 || TLW'(plen_q) > tlen_q) begin
						state_q <= S_FINAL;
					end else begin
						state_q <= S_MIN_RD;
					end
				end
				S_CLR: begin
					i_q <= i_q + 1'b1;
					if (i_q[AAW-1:0] == '1) begin
						i_q     <= '0;
						state_q <= S_CNT_RD;
					end
				end
				S_CNT_RD:  state_q <= S_CNT_INC;
				S_CNT_INC: begin
					byte_q  <= txt_rd;
					state_q <= S_CNT_WR;
				end
				S_CNT_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_CNT_RD;
					if (i_q + 1'b1 == tlen_q) begin
						i_q     <= '0;
						run_q   <= '0;
						state_q <= S_SUM_RD;
					end
				end
				S_SUM_RD: state_q <= S_SUM_WR;
				S_SUM_WR: begin
					run_q   <= run_q + cnt_rd;
					i_q     <= i_q + 1'b1;
					state_q <= S_SUM_RD;
					if (i_q[AAW-1:0] == '1) begin
						i_q     <= '0;
						state_q <= S_FIL_RD;
					end
				end
				S_FIL_RD:   state_q <= S_FIL_SLOT;
				S_FIL_SLOT: begin
					byte_q  <= txt_rd;
					state_q <= S_FIL_WR;
				end
				S_FIL_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_FIL_RD;
					if (i_q + 1'b1 == tlen_q) begin
						ready_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_MIN_RD:  state_q <= S_MIN_CNT;
				S_MIN_CNT: begin
					byte_q  <= pat_rd;
					state_q <= S_MIN_CMP;
				end
				S_MIN_CMP: begin
					if (cnt_rd < minc_q) begin
						minc_q   <= cnt_rd;
						best_q   <= byte_q;
						anchor_q <= j_q[PAW-1:0];
					end
					j_q     <= j_q + 1'b1;
					state_q <= (j_q + 1'b1 == plen_q) ? S_OFS_RD : S_MIN_RD;
				end
				S_OFS_RD: begin
					state_q <= (minc_q == '0) ? S_FINAL : S_OFS_SUB;
				end
				S_OFS_SUB: begin
					// fill pointers end at the bucket's end after the build
					k_q     <= fil_rd - minc_q;
					end_q   <= fil_rd;
					state_q <= S_POS_RD;
				end
				S_POS_RD: begin
					state_q <= (k_q == end_q) ? S_FINAL : S_POS_CHK;
				end
				S_POS_CHK: begin
					k_q     <= k_q + 1'b1;
					j_q     <= '0;
					start_q <= st;
					if (pos_rd < TAW'(anchor_q) || TLW'(st) + TLW'(plen_q) > tlen_q) begin
						state_q <= S_POS_RD;
					end else begin
						state_q <= S_CMP_RD;
					end
				end
				S_CMP_RD: state_q <= S_CMP_CHK;
				S_CMP_CHK: begin
					if (txt_rd != pat_rd) begin
						state_q <= S_POS_RD;
					end else if (j_q + 1'b1 == plen_q) begin
						if (total_q < TLW'(MAX_EMIT)) begin
							state_q <= S_EMIT;
						end else begin
							total_q <= total_q + 1'b1;
							state_q <= S_POS_RD;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_CMP_RD;
					end
				end
				S_EMIT: begin
					if (res_ready) begin
						total_q <= total_q + 1'b1;
						state_q <= S_POS_RD;
					end
				end
				S_FINAL: begin
					if (res_ready) begin
						plen_q  <= '0;
						pover_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_emit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (total_q < TLW'(MAX_EMIT)))
		else $error("match emitted beyond cap");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POS_RD) |-> (k_q <= end_q))
		else $error("anchor walk passed bucket end");
	a_walk_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POS_CHK) |-> ready_q)
		else $error("anchor walk without index");
	a_fin_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.fin) |=> (plen_q == '0 && !pover_q))
		else $error("pattern not cleared after search");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps
module tb;
	import rcats_pkg::*;

	// Byte kinds on the input channel.
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_PAT  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} in_word_t;

	// Directed row: one input word, plus an optional typed-in closing result.
	typedef struct {
		in_word_t   w;
		bit         fixed;
		logic [12:0] cnt;
		status_t    st;
	} drow_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  data_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] match_position;
	logic        match_valid;
	logic [12:0] match_count;
	logic        count_overflow;
	logic [1:0]  status;
	logic        final_result;

	rare_char_anchored_text_search dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .data_byte(data_byte), .end_of_string(end_of_string),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_position(match_position), .match_valid(match_valid),
		.match_count(match_count), .count_overflow(count_overflow),
		.status(status), .final_result(final_result)
	);

	// Predictor state: a shadow of the text and pattern stores.
	logic [7:0]  txt_mem [TEXT_DEPTH];
	int          txt_len;
	bit          txt_indexed;
	logic [7:0]  pat_mem [PATTERN_DEPTH];
	int          pat_len;
	bit          pat_dropped;

	result_t     pending_results[$];
	in_word_t    send_q[$];
	bit          fixed_q[$];
	logic [12:0] fixed_cnt_q[$];
	status_t     fixed_st_q[$];

	int  errors = 0;
	int  words_sent = 0;
	int  results_seen = 0;
	int  searches = 0;
	bit  calm = 0;
	bit  hold_off = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Run guard: far beyond the slowest correct run.
	initial begin
		#40_000_000;
		$display("rare_char_anchored_text_search: mismatch");
		$finish;
	end

	function automatic result_t close_word(int total, status_t st);
		result_t r;
		r = '0;
		r.count = (total > 8191) ? 13'd8191 : 13'(total);
		r.ovf = total > MAX_EMIT;
		r.status = st;
		r.fin = 1;
		return r;
	endfunction

	// Search the shadow text directly: every start whose whole span fits.
	// Ascending starts give the same order as the anchor walk.
	task automatic search_text();
		int total;
		bit hit;
		result_t r;
		total = 0;
		searches++;
		if (pat_dropped) begin
			pending_results.push_back(close_word(0, STAT_PAT_LONG));
			return;
		end
		if (!txt_indexed) begin
			pending_results.push_back(close_word(0, STAT_NO_TEXT));
			return;
		end
		if (pat_len == 0 || pat_len > txt_len) begin
			pending_results.push_back(close_word(0, STAT_OK));
			return;
		end
		for (int s = 0; s + pat_len <= txt_len; s++) begin
			hit = 1;
			for (int j = 0; j < pat_len; j++)
				if (txt_mem[s + j] != pat_mem[j]) begin
					hit = 0;
					break;
				end
			if (hit) begin
				if (total < MAX_EMIT) begin
					r = '0;
					r.pos = 12'(s);
					r.valid = 1;
					pending_results.push_back(r);
				end
				total++;
			end
		end
		pending_results.push_back(close_word(total, STAT_OK));
	endtask

	// Advance the shadow by one accepted word.
	task automatic absorb_word(in_word_t w);
		if (w.kind == KIND_TEXT) begin
			if (txt_indexed) begin
				txt_indexed = 0;
				txt_len = 0;
			end
			if (txt_len < TEXT_DEPTH) begin
				txt_mem[txt_len] = w.data;
				txt_len++;
			end
			if (w.last) txt_indexed = 1;
		end else begin
			if (pat_len < PATTERN_DEPTH) begin
				pat_mem[pat_len] = w.data;
				pat_len++;
			end else
				pat_dropped = 1;
			if (w.last) begin
				search_text();
				pat_len = 0;
				pat_dropped = 0;
			end
		end
	endtask

	task automatic queue_word(logic kind, logic [7:0] d, logic last);
		in_word_t w;
		w.kind = kind;
		w.data = d;
		w.last = last;
		send_q.push_back(w);
		fixed_q.push_back(0);
		fixed_cnt_q.push_back('0);
		fixed_st_q.push_back(STAT_OK);
	endtask

	// Driver: present the head word, drop it once accepted, idle in bursts.
	initial begin
		in_word_t w;
		in_valid = 0;
		req_type = 0;
		data_byte = 0;
		end_of_string = 0;
		arst_n = 0;
		txt_len = 0;
		txt_indexed = 0;
		pat_len = 0;
		pat_dropped = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				w = send_q.pop_front();
				if (fixed_q.pop_front()) begin
					// Typed-in closing result replaces the predicted one.
					absorb_word(w);
					void'(pending_results.pop_back());
					pending_results.push_back(close_word(0, fixed_st_q[0]));
					pending_results[$].count = fixed_cnt_q[0];
				end else
					absorb_word(w);
				void'(fixed_cnt_q.pop_front());
				void'(fixed_st_q.pop_front());
				words_sent++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_q.size() != 0 && (calm || $urandom_range(0, 5) != 0)) begin
					in_valid <= 1;
					req_type <= send_q[0].kind;
					data_byte <= send_q[0].data;
					end_of_string <= send_q[0].last;
				end else begin
					in_valid <= 0;
					if (send_q.size() != 0)
						repeat ($urandom_range(1, 11) - 1) @(posedge clk);
				end
			end
		end
	end

	// Receiver: compare each accepted result with the oldest expectation.
	initial begin
		result_t exp;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result pos=%0d fin=%0b", $time,
						match_position, final_result);
				end else begin
					exp = pending_results.pop_front();
					if (match_position !== exp.pos || match_valid !== exp.valid ||
						match_count !== exp.count || count_overflow !== exp.ovf ||
						status !== exp.status || final_result !== exp.fin) begin
						errors++;
						$display("%0t: expected pos=%0d v=%0b cnt=%0d ovf=%0b st=%0d fin=%0b",
							$time, exp.pos, exp.valid, exp.count, exp.ovf,
							exp.status, exp.fin);
						$display("%0t:   actual pos=%0d v=%0b cnt=%0d ovf=%0b st=%0d fin=%0b",
							$time, match_position, match_valid, match_count,
							count_overflow, status, final_result);
					end
				end
			end
			if (hold_off)
				out_stall <= 1;
			else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 11) - 1) @(posedge clk);
			end else
				out_stall <= 0;
		end
	end

	// Long receiver hold-off so the block backs up and stalls its input.
	initial begin
		wait (words_sent > 120);
		hold_off = 1;
		repeat (3000) @(posedge clk);
		hold_off = 0;
	end

	task automatic queue_string(logic kind, byte unsigned s[]);
		foreach (s[i]) queue_word(kind, s[i], i == s.size() - 1);
	endtask

	// Generate a well-formed text and a pattern often cut from it.
	task automatic random_session(int n_pat);
		byte unsigned t[];
		byte unsigned p[];
		int tl, pl, st, span;
		span = $urandom_range(2, 255);
		tl = $urandom_range(1, 40);
		t = new[tl];
		foreach (t[i]) t[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 2) + span - 2);
		queue_string(KIND_TEXT, t);
		repeat (n_pat) begin
			pl = $urandom_range(1, 5);
			p = new[pl];
			st = $urandom_range(0, tl - 1);
			foreach (p[i]) p[i] = ($urandom_range(0, 4) != 0 && st + i < tl) ? t[st + i]
				: 8'($urandom_range(0, 255));
			queue_string(KIND_PAT, p);
		end
	endtask

	// Stimulus plan and end of run.
	initial begin
		drow_t rows[$];
		drow_t r;
		byte unsigned bulk[];
		string s;
		int guard;
		// Pattern before any text: no index.
		r.w = '{KIND_PAT, 8'h41, 1'b1}; r.fixed = 1; r.cnt = 0; r.st = STAT_NO_TEXT;
		rows.push_back(r);
		r.fixed = 0;
		s = "ABAB";
		for (int i = 0; i < s.len(); i++) begin
			r.w = '{KIND_TEXT, 8'(s[i]), 1'(i == s.len() - 1)};
			rows.push_back(r);
		end
		// "AB" twice, then extremes, an absent byte, a too-long pattern.
		r.w = '{KIND_PAT, 8'h41, 1'b0}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'h42, 1'b1}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'h00, 1'b1}; r.fixed = 1; r.cnt = 0; r.st = STAT_OK;
		rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b1}; rows.push_back(r);
		r.fixed = 0;
		s = "ABABA";
		for (int i = 0; i < s.len(); i++) begin
			r.w = '{KIND_PAT, 8'(s[i]), 1'(i == s.len() - 1)};
			rows.push_back(r);
		end
		// New text with extreme bytes; match at the very end.
		r.w = '{KIND_TEXT, 8'h00, 1'b0}; rows.push_back(r);
		r.w = '{KIND_TEXT, 8'hFF, 1'b0}; rows.push_back(r);
		r.w = '{KIND_TEXT, 8'hFF, 1'b1}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b0}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b1}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b0}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b0}; rows.push_back(r);
		r.w = '{KIND_PAT, 8'hFF, 1'b1}; rows.push_back(r);
		foreach (rows[i]) begin
			queue_word(rows[i].w.kind, rows[i].w.data, rows[i].w.last);
			fixed_q[$] = rows[i].fixed;
			fixed_cnt_q[$] = rows[i].cnt;
			fixed_st_q[$] = rows[i].st;
		end
		// Many matches: 70 equal bytes, single-byte pattern overflows emission.
		bulk = new[70];
		foreach (bulk[i]) bulk[i] = 8'h5A;
		queue_string(KIND_TEXT, bulk);
		queue_word(KIND_PAT, 8'h5A, 1'b1);
		queue_word(KIND_PAT, 8'h5A, 1'b0);
		queue_word(KIND_PAT, 8'h5A, 1'b1);
		// Random sessions: mostly well-formed text then patterns.
		while (send_q.size() < 200) begin
			if ($urandom_range(0, 9) == 0)
				queue_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			else
				random_session($urandom_range(2, 6));
		end
		// Last stretch with no idling.
		wait (send_q.size() < 30);
		calm = 1;
		random_session(3);
		wait (send_q.size() == 0);
		@(posedge clk);
		guard = 0;
		while (pending_results.size() != 0 && guard < 2_000_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		$display("Sent %0d words, ran %0d searches, checked %0d results.",
			words_sent, searches, results_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("rare_char_anchored_text_search: match");
		else
			$display("rare_char_anchored_text_search: mismatch");
		$finish;
	end
endmodule
